// ----- src/matrix_keypad_scan_debounce_top_assert.svh -----
// assertion macros for the keypad scanner checker
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_TOP_ASSERT_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_TOP_ASSERT_SVH

// same-cycle implication, clocked and held off during reset
`define MKPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked and held off during reset
`define MKPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mkpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mkpd_pkg
// shared types and constants of the keypad scanner with debounce
// ----------------------------------------------------------------------------
package mkpd_pkg;

    // sizes
    localparam int NUM_KEYS  = 10;
    localparam int CTR_W     = 8;
    localparam int REG_W     = 8;
    localparam int CMP_W     = (CTR_W > REG_W) ? CTR_W : REG_W;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 2;
    localparam int IDX_W     = 2;
    localparam int BUTTON_IX = NUM_KEYS - 1;

    localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

    typedef logic [CTR_W-1:0]    t_ctr;
    typedef logic [NUM_KEYS-1:0] t_keys;

    // debounce settings
    typedef struct packed {
        logic [REG_W-1:0] ceiling;
        logic [REG_W-1:0] press_thr;
        logic [REG_W-1:0] release_thr;
    } t_cfg;

    localparam t_cfg CFG_RST = '{ceiling: REG_W'(10), press_thr: REG_W'(5),
                                 release_thr: REG_W'(3)};

    // register indexes
    localparam logic [IDX_W-1:0] REG_CEILING = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RELEASE = 2'd2;

    // scan phases
    localparam logic [1:0] PH_UNDEF = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;
    localparam logic [1:0] PH_THREE = 2'd3;

    // driven column codes
    localparam logic [COL_W-1:0] COL_NONE  = 2'd0;
    localparam logic [COL_W-1:0] COL_ONE   = 2'd1;
    localparam logic [COL_W-1:0] COL_TWO   = 2'd2;
    localparam logic [COL_W-1:0] COL_THREE = 2'd3;

endpackage

// ----- src/matrix_keypad_scan_debounce_top.sv -----
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_top
// 3x3 keypad plus direct button scanner with per-key counter debounce
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready  | i_row_levels, i_button_level
//  out      | o_out_valid / i_out_ready| o_drive_column, o_key_mask,
//           |                          | o_mask_updated
//  cfg      | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_wdata
//
//  one beat per cycle sustained while the output is not stalled; a beat passes
//  the input register, then scan state and result register updated together in one pass.
//  a stalled output holds its beat and the input register takes one more.
//  synchronous active-low reset clears phase, masks and counters and loads default settings.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mkpd_pkg::ROW_W-1:0]   i_row_levels,
    input  logic                         i_button_level,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mkpd_pkg::COL_W-1:0]   o_drive_column,
    output logic [mkpd_pkg::NUM_KEYS-1:0] o_key_mask,
    output logic                         o_mask_updated,
    input  logic                         i_cfg_we,
    input  logic [mkpd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mkpd_pkg::REG_W-1:0]   i_cfg_wdata
);
    import mkpd_pkg::*;

    t_cfg               r_cfg;
    logic               r_s1_valid;
    logic [ROW_W-1:0]   r_s1_rows;
    logic               r_s1_button;
    logic               r_out_valid;
    logic [COL_W-1:0]   r_col;
    t_keys              r_out_mask;
    logic               r_upd;
    logic [1:0]         r_phase;
    t_keys              r_raw;
    t_keys              r_mask;
    t_ctr               r_ctr [NUM_KEYS];

    logic               adv;
    logic [1:0]         n_phase;
    t_keys              n_raw;
    logic [COL_W-1:0]   n_col;
    logic               n_upd;
    t_keys              deb_mask;
    t_ctr               deb_ctr [NUM_KEYS];

    // handshakes
    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;

    // settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CEILING: r_cfg.ceiling     <= i_cfg_wdata;
                REG_PRESS:   r_cfg.press_thr   <= i_cfg_wdata;
                REG_RELEASE: r_cfg.release_thr <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_rows   <= i_row_levels;
            r_s1_button <= i_button_level;
        end
    end

    // phase decode and row sampling
    always_comb begin
        n_raw   = r_raw;
        n_phase = PH_ONE;
        n_col   = COL_NONE;
        n_upd   = 1'b0;
        unique case (r_phase)
            PH_UNDEF: begin
                n_phase = PH_ONE;
            end
            PH_ONE: begin
                n_raw[ROW_W-1:0] = ~r_s1_rows;
                n_col            = COL_ONE;
                n_phase          = PH_TWO;
            end
            PH_TWO: begin
                n_raw[2*ROW_W-1:ROW_W] = ~r_s1_rows;
                n_col                  = COL_TWO;
                n_phase                = PH_THREE;
            end
            PH_THREE: begin
                n_raw[3*ROW_W-1:2*ROW_W] = ~r_s1_rows;
                n_col                    = COL_THREE;
                n_upd                    = 1'b1;
                n_phase                  = PH_ONE;
            end
            default: ;
        endcase
        if (r_phase != PH_UNDEF) begin
            n_raw[BUTTON_IX] = ~r_s1_button;
        end
    end

    // counter update
    mkpd_debounce u_debounce (
        .i_cfg  (r_cfg),
        .i_raw  (n_raw),
        .i_mask (r_mask),
        .i_ctr  (r_ctr),
        .o_ctr  (deb_ctr),
        .o_mask (deb_mask)
    );

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UNDEF;
            r_raw   <= '0;
            r_mask  <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_ctr[k] <= '0;
            end
        end else if (adv) begin
            r_phase <= n_phase;
            r_raw   <= n_raw;
            if (n_upd) begin
                r_mask <= deb_mask;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_ctr[k] <= deb_ctr[k];
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_col      <= n_col;
            r_upd      <= n_upd;
            r_out_mask <= n_upd ? deb_mask : r_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_column = r_col;
    assign o_key_mask     = r_out_mask;
    assign o_mask_updated = r_upd;

endmodule

// ----- src/mkpd_debounce.sv -----
// ----------------------------------------------------------------------------
// mkpd_debounce
// next counter values and debounced mask for all keys in parallel
// ----------------------------------------------------------------------------
module mkpd_debounce (
    input  mkpd_pkg::t_cfg  i_cfg,
    input  mkpd_pkg::t_keys i_raw,
    input  mkpd_pkg::t_keys i_mask,
    input  mkpd_pkg::t_ctr  i_ctr [mkpd_pkg::NUM_KEYS],
    output mkpd_pkg::t_ctr  o_ctr [mkpd_pkg::NUM_KEYS],
    output mkpd_pkg::t_keys o_mask
);
    import mkpd_pkg::*;

    // one saturating up/down counter and hysteresis test per key
    always_comb begin
        logic [CMP_W-1:0] c_ext;
        t_ctr             c_nxt;
        o_mask = i_mask;
        for (int k = 0; k < NUM_KEYS; k++) begin
            c_ext = CMP_W'(i_ctr[k]);
            c_nxt = i_ctr[k];
            if (i_raw[k]) begin
                if (c_ext < CMP_W'(i_cfg.ceiling) && i_ctr[k] != CTR_MAX) begin
                    c_nxt = i_ctr[k] + t_ctr'(1);
                end
                if (CMP_W'(c_nxt) > CMP_W'(i_cfg.press_thr)) begin
                    o_mask[k] = 1'b1;
                end
            end else begin
                if (i_ctr[k] != '0) begin
                    c_nxt = i_ctr[k] - t_ctr'(1);
                end
                if (CMP_W'(c_nxt) < CMP_W'(i_cfg.release_thr)) begin
                    o_mask[k] = 1'b0;
                end
            end
            o_ctr[k] = c_nxt;
        end
    end

endmodule

// ----- src/mkpd_checker.sv -----
// ----------------------------------------------------------------------------
// mkpd_checker
// port-level checks of the keypad scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix_keypad_scan_debounce_top_assert.svh"

module mkpd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mkpd_pkg::COL_W-1:0]    o_drive_column,
    input logic [mkpd_pkg::NUM_KEYS-1:0] o_key_mask,
    input logic                          o_mask_updated
);
    import mkpd_pkg::*;

    // a stalled result beat holds
    `MKPD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_drive_column) && $stable(o_key_mask)
        && $stable(o_mask_updated), "result beat changed while stalled")

    // the debounce update runs exactly on the third column
    `MKPD_ASSERT_IMPL(a_upd_col, o_out_valid,
        o_mask_updated == (o_drive_column == COL_THREE),
        "update flag does not match third column")

    // the tick out of the undefined phase sees no debounced key yet
    `MKPD_ASSERT_IMPL(a_first_mask, o_out_valid && o_drive_column == COL_NONE,
        o_key_mask == '0 && !o_mask_updated,
        "first tick shows keys or an update")

endmodule

bind matrix_keypad_scan_debounce_top mkpd_checker u_mkpd_checker (.*);
